// File: rtl/erqc_pkg.sv
// ----------------------------------------------------------------------------
// erqc_pkg
// Shared types and constants of the elevator request queue controller.
// ----------------------------------------------------------------------------
package erqc_pkg;

   localparam int FLOOR_W    = 6;
   localparam int NUM_FL_W   = 7;
   localparam int PENDING_W  = 5;
   localparam int MAX_FLOORS = 64;
   localparam int LIMIT_W    = 9;

   localparam logic FUNC_TICK    = 1'b0;
   localparam logic FUNC_REQUEST = 1'b1;

   localparam logic [NUM_FL_W-1:0] NUM_FLOORS_RESET = 7'd64;

   typedef struct packed {
      logic               func;
      logic [FLOOR_W-1:0] floor;
   } req_type;

   typedef struct packed {
      logic [FLOOR_W-1:0]   floor_now;
      logic [FLOOR_W-1:0]   floor_target;
      logic                 door_open;
      logic [PENDING_W-1:0] pending_count;
      logic                 dropped;
   } rsp_type;

   // per-cell controls
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

   // queue-level controls from the sequencer
   typedef struct packed {
      logic append;
      logic remove_one;
   } queue_ctl_type;

   // queue status back to the sequencer
   typedef struct packed {
      logic               hit;
      logic [FLOOR_W-1:0] head;
   } queue_stat_type;

endpackage

// File: rtl/elevator_request_queue_controller.sv
// Flow: an accepted request or plain tick goes to S_EMIT, which registers its result
//    once the output register is free; a door-closing tick first walks S_REMOVE.
// Input: a new item is taken only in S_IDLE, after the last result is registered,
//    and while that result waits; a door-closing tick holds it during the removal walk.
// Reset: synchronous, active high; clears the count, floors, door and the
//    output beat; num_floors returns to 64. Queue cells are not cleared.
// ----------------------------------------------------------------------------
// elevator_request_queue_controller
// Single-car controller: queue of requested floors in a row of cells, car
// position, target floor and door flag, stepped by tick and request beats.
// ----------------------------------------------------------------------------
module elevator_request_queue_controller #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  erqc_pkg::req_type              req_data,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output erqc_pkg::rsp_type              rsp_data,
   // num_floors register write
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [erqc_pkg::NUM_FL_W-1:0]  csr_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_REMOVE = 3'b010,
      S_EMIT   = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [erqc_pkg::FLOOR_W-1:0]  cur_ff, cur_in;
   logic [erqc_pkg::FLOOR_W-1:0]  tgt_ff, tgt_in;
   logic                          door_ff, door_in;
   logic                          drop_ff, drop_in;
   logic [erqc_pkg::NUM_FL_W-1:0] num_floors_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   erqc_pkg::rsp_type             rsp_ff, rsp_in;

   erqc_pkg::queue_ctl_type  q_ctl;
   erqc_pkg::queue_stat_type q_stat;
   logic [CNT_W-1:0]         q_count;
   logic [CNT_W+4:0]         count_wide;

   logic req_fire;
   logic out_free;
   logic reject;

   // The key is always the car's floor: the match flag answers "is the
   // current floor queued" and also drives the removal walk.
   erqc_chain #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .CNT_W       (CNT_W)
   ) u_chain (
      .clock   (clock),
      .reset   (reset),
      .ctl     (q_ctl),
      .key     (cur_ff),
      .wr_data (req_data.floor),
      .stat    (q_stat),
      .count   (q_count)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // drop on full queue, floor beyond the configured count or the hard limit
   assign reject = (q_count == CNT_W'(QUEUE_DEPTH))
                || ({1'b0, req_data.floor} >= num_floors_ff)
                || (erqc_pkg::LIMIT_W'(req_data.floor)
                    >= erqc_pkg::LIMIT_W'(erqc_pkg::MAX_FLOORS));

   assign count_wide = (CNT_W + 5)'(q_count);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      tgt_in       = tgt_ff;
      door_in      = door_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      q_ctl        = '0;

      // retire the waiting beat
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               drop_in  = 1'b0;
               state_in = S_EMIT;
               if (req_data.func == erqc_pkg::FUNC_REQUEST) begin
                  if (reject) begin
                     drop_in = 1'b1;
                  end else begin
                     q_ctl.append = 1'b1;
                     // retarget to the head; an empty queue's head is this floor
                     tgt_in = (q_count == '0) ? req_data.floor : q_stat.head;
                  end
               end else if (q_stat.hit) begin
                  if (door_ff) begin
                     door_in  = 1'b0;
                     state_in = S_REMOVE;
                  end else begin
                     door_in = 1'b1;
                  end
               end else if (!door_ff) begin
                  if (tgt_ff > cur_ff) begin
                     cur_in = cur_ff + erqc_pkg::FLOOR_W'(1);
                  end else if (tgt_ff < cur_ff) begin
                     cur_in = cur_ff - erqc_pkg::FLOOR_W'(1);
                  end
               end
            end
         end
         S_REMOVE: begin
            // drop one matching entry per cycle, then reload the target
            if (q_stat.hit) begin
               q_ctl.remove_one = 1'b1;
            end else begin
               if (q_count != '0) begin
                  tgt_in = q_stat.head;
               end
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_in.floor_now     = cur_ff;
               rsp_in.floor_target  = tgt_ff;
               rsp_in.door_open     = door_ff;
               rsp_in.pending_count = count_wide[erqc_pkg::PENDING_W-1:0];
               rsp_in.dropped       = drop_ff;
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cur_ff        <= '0;
         tgt_ff        <= '0;
         door_ff       <= 1'b0;
         drop_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         num_floors_ff <= erqc_pkg::NUM_FLOORS_RESET;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         tgt_ff       <= tgt_in;
         door_ff      <= door_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            num_floors_ff <= csr_data;
         end
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/erqc_cell.sv
// ----------------------------------------------------------------------------
// erqc_cell
// One queue slot: holds a floor, flags a match against the key and shifts
// its neighbor's floor in while a removal ripples past it.
// ----------------------------------------------------------------------------
module erqc_cell (
   input  logic                         clock,
   input  erqc_pkg::cell_ctl_type       ctl,
   input  logic                         occupied,
   input  logic [erqc_pkg::FLOOR_W-1:0] key,
   input  logic [erqc_pkg::FLOOR_W-1:0] wr_data,
   input  logic [erqc_pkg::FLOOR_W-1:0] right_data,
   input  logic                         shift_in,
   output logic [erqc_pkg::FLOOR_W-1:0] entry,
   output logic                         shift_out,
   output logic                         hit
);

   logic [erqc_pkg::FLOOR_W-1:0] entry_ff;

   assign hit       = occupied && (entry_ff == key);
   assign shift_out = shift_in || hit;
   assign entry     = entry_ff;

   always_ff @(posedge clock) begin
      if (ctl.shift && shift_out) begin
         entry_ff <= right_data;
      end else if (ctl.load) begin
         entry_ff <= wr_data;
      end
   end

endmodule

// File: rtl/erqc_chain.sv
// ----------------------------------------------------------------------------
// erqc_chain
// Row of queue cells with the fill count. Appends at the tail, removes the
// first entry equal to the key per cycle by shifting the rest toward the head.
// ----------------------------------------------------------------------------
module erqc_chain #(
   parameter int QUEUE_DEPTH = 16,
   parameter int CNT_W       = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  erqc_pkg::queue_ctl_type      ctl,
   input  logic [erqc_pkg::FLOOR_W-1:0] key,
   input  logic [erqc_pkg::FLOOR_W-1:0] wr_data,
   output erqc_pkg::queue_stat_type     stat,
   output logic [CNT_W-1:0]             count
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic [erqc_pkg::FLOOR_W-1:0] entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH:0]         shift_chain;
   logic [QUEUE_DEPTH-1:0]       hits;

   assign shift_chain[0] = 1'b0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      erqc_pkg::cell_ctl_type       cell_ctl;
      logic [erqc_pkg::FLOOR_W-1:0] right_data;

      assign cell_ctl.load  = ctl.append && (CNT_W'(i) == count_ff);
      assign cell_ctl.shift = ctl.remove_one;

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_data = entry[i];
      end else begin : g_body
         assign right_data = entry[i+1];
      end

      erqc_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .occupied   (CNT_W'(i) < count_ff),
         .key        (key),
         .wr_data    (wr_data),
         .right_data (right_data),
         .shift_in   (shift_chain[i]),
         .entry      (entry[i]),
         .shift_out  (shift_chain[i+1]),
         .hit        (hits[i])
      );
   end

   assign stat.hit  = |hits;
   assign stat.head = entry[0];
   assign count     = count_ff;

   always_comb begin
      count_in = count_ff;
      if (ctl.append) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.remove_one) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/erqc_checker.sv
// ----------------------------------------------------------------------------
// erqc_checker
// Port-level checks of the elevator request queue controller.
// ----------------------------------------------------------------------------
module erqc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input erqc_pkg::req_type             req_data,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input erqc_pkg::rsp_type             rsp_data,
   input logic                          csr_valid,
   input logic                          csr_ready,
   input logic [erqc_pkg::NUM_FL_W-1:0] csr_data
);

   // no result beat right after reset
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat present after reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // an open door is reported only with a nonempty queue
   a_door_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.door_open |-> rsp_data.pending_count != '0)
      else $error("door open with empty queue");

   // with nothing queued the car rests at its target
   a_idle_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.pending_count == '0)
      |-> rsp_data.floor_now == rsp_data.floor_target)
      else $error("empty queue but car away from target");

endmodule

bind elevator_request_queue_controller erqc_checker u_erqc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_data  (csr_data)
);
